// ===== rtl/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants for the chunked body decoder
// Holds the phase and header-parse state codes, report codes and the result
// record that the output queue stores.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

  // Top-level phase of the body parse
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_DATA    = 2'd1,
    PH_SKIP    = 2'd2,
    PH_STOPPED = 2'd3
  } phase_t;

  // Position inside a chunk size line
  typedef enum logic [2:0] {
    SUB_LEAD    = 3'd0,
    SUB_ZERO    = 3'd1,
    SUB_AFTER_X = 3'd2,
    SUB_DIGITS  = 3'd3,
    SUB_TRAIL   = 3'd4,
    SUB_EXT     = 3'd5,
    SUB_BAD     = 3'd6
  } sub_t;

  // End-of-body report codes
  typedef enum logic [1:0] {
    ST_TERMINATED = 2'd0,
    ST_MALFORMED  = 2'd1,
    ST_TRUNCATED  = 2'd2
  } status_t;

  // Result kind
  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // Bits per hex digit
  localparam int unsigned HEX_BITS = 4;

  // One queued result
  typedef struct packed {
    kind_t      kind;
    status_t    status;
    logic [7:0] data;
  } res_t;

endpackage : cbd_pkg

`default_nettype wire

// ===== rtl/chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// chunked_body_decoder: HTTP chunked transfer body decoder
// Parses chunk size lines, passes chunk payload bytes through and reports
// how each body ended on its last byte.
// ----------------------------------------------------------------------------
// The decoder takes one body byte per cycle. Each request is handled in the
// cycle it is accepted: the parse state updates and zero, one or two results
// (a payload byte and/or the end report) are written into a four-entry
// result queue, which drains one result per cycle while the output side takes them.
// in_tready stays high while the queue has room for two results, so with
// the output side taking results the block sustains one byte per cycle;
// only a stalled output side slows it down. The end report comes after the
// payload byte when both fall on the last byte of a body, and the parse
// state returns to its reset value for the next body.
`default_nettype none

module chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = 31
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input requests
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // body_end
  // results
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [15:0]     out_tdata,  // [7:0] out_byte, [9:8] end_status, [15:10] zero
  output logic            out_tuser   // out_kind
);

  import cbd_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    sub_t                 sub;
    logic [SIZE_BITS-1:0] acc;
    logic                 seen;
  } line_t;

  // --------------------------------------------------------------------------
  // Character helpers
  // --------------------------------------------------------------------------
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [HEX_BITS-1:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    return v[HEX_BITS-1:0];
  endfunction

  // Shift one digit into the size, flag overflow past SIZE_BITS
  function automatic line_t add_digit(input line_t l, input logic [HEX_BITS-1:0] d);
    line_t o;
    o = l;
    if (|l.acc[SIZE_BITS-1 -: HEX_BITS]) begin
      o.sub = SUB_BAD;
    end else begin
      o.acc  = {l.acc[SIZE_BITS-HEX_BITS-1:0], d};
      o.seen = 1'b1;
      o.sub  = SUB_DIGITS;
    end
    return o;
  endfunction

  // Advance the size line parse by one character
  function automatic line_t feed(input line_t l, input logic [7:0] c);
    line_t o;
    logic  hx;
    logic  sp;
    o  = l;
    hx = is_hex(c);
    sp = is_space(c);
    case (l.sub)
      SUB_LEAD: begin
        if (sp) begin
          o = l;
        end else if (c == CH_SEMI) begin
          o.sub = SUB_EXT;
        end else if (c == CH_ZERO) begin
          o.acc  = '0;
          o.seen = 1'b1;
          o.sub  = SUB_ZERO;
        end else if (hx) begin
          o.acc  = SIZE_BITS'(hex_val(c));
          o.seen = 1'b1;
          o.sub  = SUB_DIGITS;
        end else begin
          o.sub = SUB_BAD;
        end
      end
      SUB_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) begin
          o.seen = 1'b0;
          o.sub  = SUB_AFTER_X;
        end else if (hx) begin
          o = add_digit(l, hex_val(c));
        end else if (sp) begin
          o.sub = SUB_TRAIL;
        end else if (c == CH_SEMI) begin
          o.sub = SUB_EXT;
        end else begin
          o.sub = SUB_BAD;
        end
      end
      SUB_AFTER_X: begin
        if (hx) begin
          o = add_digit(l, hex_val(c));
        end else begin
          o.sub = SUB_BAD;
        end
      end
      SUB_DIGITS: begin
        if (hx) begin
          o = add_digit(l, hex_val(c));
        end else if (sp) begin
          o.sub = SUB_TRAIL;
        end else if (c == CH_SEMI) begin
          o.sub = SUB_EXT;
        end else begin
          o.sub = SUB_BAD;
        end
      end
      SUB_TRAIL: begin
        if (sp) begin
          o = l;
        end else if (c == CH_SEMI) begin
          o.sub = SUB_EXT;
        end else begin
          o.sub = SUB_BAD;
        end
      end
      default: begin
        o = l;
      end
    endcase
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Parse state
  // --------------------------------------------------------------------------
  phase_t               phase_r,   phase_nxt;
  sub_t                 sub_r,     sub_nxt;
  logic                 pend_cr_r, pend_cr_nxt;
  logic [SIZE_BITS-1:0] chunk_r,   chunk_nxt;
  logic [1:0]           skip_r,    skip_nxt;
  logic                 seen_r,    seen_nxt;
  status_t              stop_r,    stop_nxt;

  // Result queue
  res_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  logic       in_fire;
  logic       out_fire;
  res_t       res0;
  res_t       res1;
  logic [1:0] n_res;
  logic [1:0] n_push;
  logic [7:0] c;
  line_t      ln;
  logic       line_done;

  assign c         = in_tdata;
  assign in_tready = (count_r <= QCNT_W'(QDEPTH - 2));
  assign in_fire   = in_tvalid & in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_fire  = out_tvalid & out_tready;

  // Compute next parse state and the results of the byte on the input
  always_comb begin
    phase_nxt   = phase_r;
    sub_nxt     = sub_r;
    pend_cr_nxt = pend_cr_r;
    chunk_nxt   = chunk_r;
    skip_nxt    = skip_r;
    seen_nxt    = seen_r;
    stop_nxt    = stop_r;
    res0        = '{kind: KIND_DATA, status: ST_TERMINATED, data: 8'h00};
    res1        = '{kind: KIND_DATA, status: ST_TERMINATED, data: 8'h00};
    n_res       = 2'd0;
    ln          = '{sub: sub_r, acc: chunk_r, seen: seen_r};
    line_done   = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        // resolve a held CR: line end on LF, else it is plain whitespace
        if (pend_cr_r) begin
          pend_cr_nxt = 1'b0;
          if (c == CH_LF) begin
            line_done = 1'b1;
          end else begin
            ln = feed(ln, CH_CR);
          end
        end
        if (line_done) begin
          if (sub_r == SUB_BAD || !seen_r) begin
            phase_nxt = PH_STOPPED;
            stop_nxt  = ST_MALFORMED;
          end else if (chunk_r == '0) begin
            phase_nxt = PH_STOPPED;
            stop_nxt  = ST_TERMINATED;
          end else begin
            phase_nxt = PH_DATA;
          end
          sub_nxt  = SUB_LEAD;
          seen_nxt = 1'b0;
        end else begin
          if (c == CH_CR) begin
            pend_cr_nxt = 1'b1;
          end else begin
            ln = feed(ln, c);
          end
          sub_nxt   = ln.sub;
          chunk_nxt = ln.acc;
          seen_nxt  = ln.seen;
        end
      end
      PH_DATA: begin
        // pass the payload byte and count down the chunk
        res0      = '{kind: KIND_DATA, status: ST_TERMINATED, data: c};
        n_res     = 2'd1;
        chunk_nxt = chunk_r - SIZE_BITS'(1);
        if (chunk_nxt == '0) begin
          phase_nxt = PH_SKIP;
          skip_nxt  = 2'd2;
        end
      end
      PH_SKIP: begin
        // drop the chunk trailer bytes
        skip_nxt = skip_r - 2'd1;
        if (skip_nxt == 2'd0) begin
          phase_nxt = PH_HEADER;
          sub_nxt   = SUB_LEAD;
          seen_nxt  = 1'b0;
          chunk_nxt = '0;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    // append the end report and clear state for the next body
    if (in_tlast) begin
      if (n_res == 2'd0) begin
        res0 = '{kind: KIND_REPORT,
                 status: (phase_nxt == PH_STOPPED) ? stop_nxt : ST_TRUNCATED,
                 data: 8'h00};
      end else begin
        res1 = '{kind: KIND_REPORT,
                 status: (phase_nxt == PH_STOPPED) ? stop_nxt : ST_TRUNCATED,
                 data: 8'h00};
      end
      n_res       = n_res + 2'd1;
      phase_nxt   = PH_HEADER;
      sub_nxt     = SUB_LEAD;
      pend_cr_nxt = 1'b0;
      chunk_nxt   = '0;
      skip_nxt    = 2'd0;
      seen_nxt    = 1'b0;
      stop_nxt    = ST_TERMINATED;
    end
  end

  assign n_push = in_fire ? n_res : 2'd0;

  // Hold parse state, advance on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      sub_r     <= SUB_LEAD;
      pend_cr_r <= 1'b0;
      chunk_r   <= '0;
      skip_r    <= 2'd0;
      seen_r    <= 1'b0;
      stop_r    <= ST_TERMINATED;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      sub_r     <= sub_nxt;
      pend_cr_r <= pend_cr_nxt;
      chunk_r   <= chunk_nxt;
      skip_r    <= skip_nxt;
      seen_r    <= seen_nxt;
      stop_r    <= stop_nxt;
    end
  end

  // Write results into the queue
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_mem[wr_ptr_r + QPTR_W'(1)] <= res1;
    end
  end

  // Advance queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(n_push);
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(n_push) - QCNT_W'(out_fire);
    end
  end

  // Drive the head of the queue
  assign out_tuser = q_mem[rd_ptr_r].kind;
  assign out_tdata = {6'b0, q_mem[rd_ptr_r].status, q_mem[rd_ptr_r].data};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=>
      (phase_r == PH_HEADER && sub_r == SUB_LEAD && !pend_cr_r && chunk_r == '0))
    else $error("state not cleared after body end");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (chunk_r != '0))
    else $error("data phase with empty chunk");

  a_stop_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STOPPED) |-> (stop_r == ST_TERMINATED || stop_r == ST_MALFORMED))
    else $error("stopped with early-end cause");

endmodule : chunked_body_decoder

`default_nettype wire

// ===== tb/chunked_body_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// chunked_body_decoder_tb: self-checking bench for the chunked body decoder
// Streams chunked bodies into the decoder byte by byte and predicts each
// payload byte and end report in step with the input handshakes. Directed
// bodies hit size-line forms, malformed lines and early ends. Random bodies
// then run under several input-gap and output-stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_body_decoder_tb;
  import cbd_pkg::*;

  localparam int unsigned SIZE_BITS   = 31;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 16;

  // Whitespace: space plus the TAB..CR range
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  chunked_body_decoder #(
    .SIZE_BITS(SIZE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Decoder shadow state
  phase_t                cur_phase;
  sub_t                  line_sub;
  logic                  cr_held;
  logic [SIZE_BITS-1:0]  chunk_left;
  logic [1:0]            skip_left;
  logic                  digit_seen;
  status_t               stop_cause;

  res_t        pending_results[$];
  logic [7:0]  body_q[$];
  res_t        got;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned bodies_sent   = 0;
  int unsigned payload_count = 0;
  int unsigned ended_zero    = 0;
  int unsigned ended_bad     = 0;
  int unsigned ended_early   = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output-side stall pattern
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  function automatic void clear_decoder();
    cur_phase  = PH_HEADER;
    line_sub   = SUB_LEAD;
    cr_held    = 1'b0;
    chunk_left = '0;
    skip_left  = '0;
    digit_seen = 1'b0;
    stop_cause = ST_TERMINATED;
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Shift one digit into the size, flag the line if it overflows
  function automatic void shift_in_digit(input logic [3:0] d);
    logic [SIZE_BITS+3:0] grown;
    grown = {chunk_left, d};
    if (grown[SIZE_BITS+3:SIZE_BITS] != '0) begin
      line_sub = SUB_BAD;
    end else begin
      chunk_left = grown[SIZE_BITS-1:0];
      digit_seen = 1'b1;
      line_sub   = SUB_DIGITS;
    end
  endfunction

  function automatic void feed_size_char(input logic [7:0] c);
    int d;
    d = hex_digit(c);
    case (line_sub)
      SUB_LEAD: begin
        if (is_ws(c)) begin
        end else if (c == CH_SEMI) begin
          line_sub = SUB_EXT;
        end else if (c == CH_ZERO) begin
          chunk_left = '0;
          digit_seen = 1'b1;
          line_sub   = SUB_ZERO;
        end else if (d >= 0) begin
          chunk_left = '0;
          shift_in_digit(d[3:0]);
        end else begin
          line_sub = SUB_BAD;
        end
      end
      SUB_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) begin
          digit_seen = 1'b0;
          line_sub   = SUB_AFTER_X;
        end else if (d >= 0) shift_in_digit(d[3:0]);
        else if (is_ws(c)) line_sub = SUB_TRAIL;
        else if (c == CH_SEMI) line_sub = SUB_EXT;
        else line_sub = SUB_BAD;
      end
      SUB_AFTER_X: begin
        if (d >= 0) shift_in_digit(d[3:0]);
        else line_sub = SUB_BAD;
      end
      SUB_DIGITS: begin
        if (d >= 0) shift_in_digit(d[3:0]);
        else if (is_ws(c)) line_sub = SUB_TRAIL;
        else if (c == CH_SEMI) line_sub = SUB_EXT;
        else line_sub = SUB_BAD;
      end
      SUB_TRAIL: begin
        if (is_ws(c)) begin
        end else if (c == CH_SEMI) line_sub = SUB_EXT;
        else line_sub = SUB_BAD;
      end
      default: begin
      end
    endcase
  endfunction

  // Judge the size line once its CR LF arrives
  function automatic void close_size_line();
    if (line_sub == SUB_BAD || !digit_seen) begin
      cur_phase  = PH_STOPPED;
      stop_cause = ST_MALFORMED;
    end else if (chunk_left == '0) begin
      cur_phase  = PH_STOPPED;
      stop_cause = ST_TERMINATED;
    end else begin
      cur_phase = PH_DATA;
    end
    line_sub   = SUB_LEAD;
    digit_seen = 1'b0;
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic last);
    res_t r;
    case (cur_phase)
      PH_HEADER: begin
        if (cr_held && c == CH_LF) begin
          cr_held = 1'b0;
          close_size_line();
        end else begin
          // A CR without LF is an ordinary line byte
          if (cr_held) begin
            cr_held = 1'b0;
            feed_size_char(CH_CR);
          end
          if (c == CH_CR) cr_held = 1'b1;
          else feed_size_char(c);
        end
      end
      PH_DATA: begin
        // Status field reads zero on payload bytes
        r.kind   = KIND_DATA;
        r.status = ST_TERMINATED;
        r.data   = c;
        pending_results.push_back(r);
        payload_count++;
        chunk_left = chunk_left - 1'b1;
        if (chunk_left == '0) begin
          cur_phase = PH_SKIP;
          skip_left = 2'd2;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == '0) begin
          cur_phase  = PH_HEADER;
          line_sub   = SUB_LEAD;
          digit_seen = 1'b0;
          chunk_left = '0;
        end
      end
      default: begin
      end
    endcase
    if (last) begin
      r.kind   = KIND_REPORT;
      r.status = (cur_phase == PH_STOPPED) ? stop_cause : ST_TRUNCATED;
      r.data   = '0;
      pending_results.push_back(r);
      case (r.status)
        ST_TERMINATED: ended_zero++;
        ST_MALFORMED:  ended_bad++;
        default:       ended_early++;
      endcase
      clear_decoder();
    end
  endfunction

  // -------------------------------------------------------------------------
  // Result checker
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual kind=%0d tdata=%04h",
                 $time, out_tuser, out_tdata);
      end else begin
        got = pending_results.pop_front();
        if (out_tuser !== got.kind || out_tdata[9:8] !== got.status ||
            out_tdata[7:0] !== got.data || out_tdata[15:10] !== '0) begin
          error_count++;
          $display("%0t: mismatch, expected kind=%0d status=%0d byte=%02h pad=00,",
                   $time, got.kind, got.status, got.data);
          $display("%0t:           actual kind=%0d status=%0d byte=%02h pad=%02h",
                   $time, out_tuser, out_tdata[9:8], out_tdata[7:0], out_tdata[15:10]);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Body building and sending
  // -------------------------------------------------------------------------
  function automatic void put_byte(input logic [7:0] b);
    body_q.push_back(b);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  function automatic void put_line(input string s);
    put_text(s);
    put_byte(CH_CR);
    put_byte(CH_LF);
  endfunction

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(0, 4))
      0:       return CH_TAB;
      1:       return CH_VT;
      2:       return CH_FF;
      3:       return CH_LF;
      default: return CH_SP;
    endcase
  endfunction

  function automatic string hex_text(input int count);
    string s;
    s = "";
    repeat (count) s = {s, $sformatf("%0h", $urandom_range(0, 15))};
    return ($urandom_range(0, 1) != 0) ? s.toupper() : s;
  endfunction

  // Send one request, holding valid until the decoder takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++) send_byte(body_q[i], i == body_q.size() - 1);
    body_q.delete();
    bodies_sent++;
  endtask

  // Well-formed size line in a random spelling
  function automatic void put_size_line(input int unsigned n);
    string digits;
    digits = $sformatf("%0h", n);
    if ($urandom_range(0, 1) != 0) digits = digits.toupper();
    case ($urandom_range(0, 4))
      0:       digits = {"0x", digits};
      1:       digits = {"0X", digits};
      2:       digits = {"0", digits};
      default: begin
      end
    endcase
    repeat ($urandom_range(0, 2)) put_byte(ws_byte());
    put_text(digits);
    repeat ($urandom_range(0, 2)) put_byte(ws_byte());
    if ($urandom_range(0, 3) == 0) begin
      put_byte(CH_SEMI);
      repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(0, CH_CR - 1)));
    end
    put_byte(CH_CR);
    put_byte(CH_LF);
  endfunction

  function automatic void put_chunk();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    put_size_line(len);
    repeat (len) put_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) begin
      put_byte(8'($urandom_range(0, 255)));
      put_byte(8'($urandom_range(0, 255)));
    end else begin
      put_byte(CH_CR);
      put_byte(CH_LF);
    end
  endfunction

  function automatic void put_broken_line();
    case ($urandom_range(0, 6))
      0: put_line({($urandom_range(0, 1) != 0) ? "+" : "-", hex_text($urandom_range(1, 3))});
      1: put_line({hex_text($urandom_range(1, 2)), " ", hex_text($urandom_range(1, 2))});
      2: put_line({$sformatf("%0h", $urandom_range(8, 15)), hex_text($urandom_range(7, 9))});
      3: begin
        repeat ($urandom_range(0, 2)) put_byte(ws_byte());
        put_line("");
      end
      4: put_line(($urandom_range(0, 1) != 0) ? " 0x" : "0X ");
      5: put_line({hex_text($urandom_range(1, 3)), ($urandom_range(0, 1) != 0) ? "g" : "."});
      default: repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
    endcase
    repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
  endfunction

  // Mostly well-formed bodies; some broken, some cut short
  function automatic void build_random_body();
    int cut;
    repeat ($urandom_range(0, 3)) put_chunk();
    if ($urandom_range(0, 99) < 75) begin
      put_size_line(0);
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      put_broken_line();
    end
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, body_q.size());
      while (body_q.size() > cut) void'(body_q.pop_back());
    end
    if (body_q.size() == 0) put_byte(8'($urandom_range(0, 255)));
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_basic_decode();
    // Extreme payload values, then the zero chunk and a dropped trailer
    put_line("3");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h5A);
    put_line("");
    put_line("0");
    put_line("");
    send_body();
  endtask

  task automatic test_size_line_forms();
    // Prefix, extension, lone CR, both hex cases, leading zeros
    put_line("0X2 ;ext");
    put_text("ab");
    put_line("");
    put_text(" a");
    put_byte(CH_CR);
    put_line("");
    put_text("0123456789");
    put_line("");
    put_line("0x00F\t");
    put_text("ABCDEFGHIJKLMNO");
    put_line("");
    put_line("00;last");
    put_text("xy");
    send_body();
  endtask

  task automatic test_malformed_lines();
    put_line("+5");
    put_text("z");
    send_body();
    put_line("-1");
    send_body();
    put_line("");
    send_body();
    put_line("0x");
    put_text("q");
    send_body();
    put_line("80000000");
    send_body();
    put_line("100000000");
    put_text("r");
    send_body();
    put_line("1 2");
    send_body();
    put_line("5q");
    send_body();
    put_line(";only");
    send_body();
  endtask

  task automatic test_early_end();
    // Inside an unfinished line, on a held CR, in data, in the skip, after it
    put_text("12");
    send_body();
    put_text("1");
    put_byte(CH_CR);
    send_body();
    put_line("2");
    put_text("ab");
    send_body();
    put_line("1");
    put_text("z");
    put_byte(CH_CR);
    send_body();
    put_line("1");
    put_text("z");
    put_line("");
    send_body();
    put_line("7fffffff");
    put_text("abc");
    send_body();
    put_byte(8'h00);
    send_body();
  endtask

  task automatic test_random_bodies(input int unsigned gap_pct, input int unsigned hold_pct,
                                    input int unsigned byte_count);
    int unsigned target;
    send_idle_pct = gap_pct;
    stall_pct     = hold_pct;
    target        = bytes_sent + byte_count;
    while (bytes_sent < target) begin
      build_random_body();
      send_body();
    end
  endtask

  initial begin
    clear_decoder();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_decode();
    test_size_line_forms();
    test_malformed_lines();
    test_early_end();
    test_random_bodies(0, 0, 110);
    test_random_bodies(67, 0, 110);
    test_random_bodies(0, 67, 110);
    test_random_bodies(6, 6, 110);
    in_tvalid <= 1'b0;

    // Drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d bodies (%0d bytes); %0d payload bytes passed out.",
             bodies_sent, bytes_sent, payload_count);
    $display("End reports: %0d zero chunk, %0d malformed, %0d ended early.",
             ended_zero, ended_bad, ended_early);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : chunked_body_decoder_tb

`default_nettype wire
